// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_BITS_DEF = 32;

  localparam int KIND_BITS = 3;
  localparam logic [KIND_BITS-1:0] KIND_REDUCE   = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_NEGATE   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_ADD      = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_MULTIPLY = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_DIVIDE   = 3'd4;

  // datapath phases
  typedef logic [2:0] phase_t;
  localparam phase_t PH_MUL0 = 3'd0;
  localparam phase_t PH_MUL1 = 3'd1;
  localparam phase_t PH_MUL2 = 3'd2;
  localparam phase_t PH_GCD  = 3'd3;
  localparam phase_t PH_DIVN = 3'd4;
  localparam phase_t PH_DIVD = 3'd5;

  typedef struct packed {
    logic   load;      // capture input request
    logic   start;     // set up operands of phase
    logic   step;      // one iteration of phase
    logic   commit;    // store phase result
    logic   prep;      // sign, magnitudes, zero check
    logic   out_load;  // write output register
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic zero_den;
    logic is_add;
    logic is_arith;
  } status_t;

endpackage

// ===== src/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: walks the datapath through multiply, GCD and divide phases.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  rau_pkg::status_t status_i,
  output rau_pkg::cmd_t    cmd_o
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_PREP  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;
  phase_t     phase_q, phase_d;
  logic       ovalid_q, ovalid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    ovalid_d     = ovalid_q && out_stall_i;
    cmd_o        = '0;
    cmd_o.phase  = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        phase_d = PH_MUL0;
        state_d = status_i.is_arith ? S_START : S_PREP;
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d     = S_RUN;
      end
      S_RUN: begin
        if (status_i.done) begin
          cmd_o.commit = 1'b1;
          state_d      = S_START;
          unique case (phase_q)
            PH_MUL0: phase_d = PH_MUL1;
            PH_MUL1: begin
              if (status_i.is_add) phase_d = PH_MUL2;
              else state_d = S_PREP;
            end
            PH_MUL2: state_d = S_PREP;
            PH_GCD:  phase_d = PH_DIVN;
            PH_DIVN: phase_d = PH_DIVD;
            default: state_d = S_FIN;
          endcase
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        phase_d    = PH_GCD;
        state_d    = S_START;
      end
      S_FIN: begin
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // zero denominator skips the GCD and divides
    if (state_q == S_PREP && status_i.zero_den) state_d = S_FIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_MUL0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ===== src/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// Shift-add multiplier, binary GCD and restoring divider on shared registers.
// ----------------------------------------------------------------------------
module rau_datapath #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic [rau_pkg::KIND_BITS-1:0] kind_i,
  input  logic signed [31:0]            first_num_i,
  input  logic signed [31:0]            first_den_i,
  input  logic signed [31:0]            second_num_i,
  input  logic signed [31:0]            second_den_i,
  input  rau_pkg::cmd_t                 cmd_i,
  output rau_pkg::status_t              status_o,
  output logic signed [31:0]            result_num_o,
  output logic [30:0]                   result_den_o,
  output logic                          zero_den_error_o
);
  import rau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W + 1);
  localparam int KW = $clog2(W + 1);

  logic [KIND_BITS-1:0] kind_q;
  logic [W-1:0] xn_q, xd_q, yn_q, yd_q;
  logic [W-1:0] rn_q, rd_q, mn_q, md_q, g_q, qn_q, qd_q;
  logic         neg_q, err_q;
  logic [W-1:0] ra_q, rb_q;
  logic [W-1:0] rr_q;
  logic [CW-1:0] cnt_q;
  logic [KW-1:0] k_q;
  logic signed [31:0] onum_q;
  logic [30:0]        oden_q;
  logic               oerr_q;

  logic is_add, is_mul, is_div;
  assign is_add = (kind_q == KIND_ADD);
  assign is_mul = (kind_q == KIND_MULTIPLY);
  assign is_div = (kind_q == KIND_DIVIDE);

  // multiply operands per phase
  logic [W-1:0] op_a, op_b;
  always_comb begin
    unique case (cmd_i.phase)
      PH_MUL0: begin op_a = xn_q; op_b = is_mul ? yn_q : yd_q; end
      PH_MUL1: begin
        op_a = is_add ? yn_q : xd_q;
        op_b = is_add ? xd_q : (is_div ? yn_q : yd_q);
      end
      default: begin op_a = xd_q; op_b = yd_q; end
    endcase
  end

  // restoring divide step; the remainder always fits in W bits
  logic [W:0] div_sh, div_sub;
  logic       div_ge;
  assign div_sh  = {rr_q, ra_q[W-1]};
  assign div_ge  = (div_sh >= {1'b0, rb_q});
  assign div_sub = div_sh - {1'b0, rb_q};

  logic [W-1:0] mag_n, mag_d;
  assign mag_n = rn_q[W-1] ? (W'(0) - rn_q) : rn_q;
  assign mag_d = rd_q[W-1] ? (W'(0) - rd_q) : rd_q;

  logic [W-1:0] wn;
  assign wn = neg_q ? (W'(0) - qn_q) : qn_q;

  always_comb begin
    status_o.is_add   = is_add;
    status_o.is_arith = is_add || is_mul || is_div;
    status_o.zero_den = (rd_q == '0);
    status_o.done     = (cmd_i.phase == PH_GCD) ? (ra_q == '0) : (cnt_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      xn_q   <= W'(first_num_i);
      xd_q   <= W'(first_den_i);
      yn_q   <= W'(second_num_i);
      yd_q   <= W'(second_den_i);
      rn_q   <= (kind_i == KIND_NEGATE) ? (W'(0) - W'(first_num_i)) : W'(first_num_i);
      rd_q   <= W'(first_den_i);
    end
    if (cmd_i.prep) begin
      err_q <= (rd_q == '0);
      neg_q <= rn_q[W-1] ^ rd_q[W-1];
      mn_q  <= mag_n;
      md_q  <= mag_d;
    end
    if (cmd_i.start) begin
      cnt_q <= CW'(W);
      rr_q  <= '0;
      k_q   <= '0;
      unique case (cmd_i.phase)
        PH_GCD:  begin ra_q <= mn_q; rb_q <= md_q; end
        PH_DIVN: begin ra_q <= mn_q; rb_q <= g_q;  end
        PH_DIVD: begin ra_q <= md_q; rb_q <= g_q;  end
        default: begin ra_q <= op_a; rb_q <= op_b; end
      endcase
    end
    if (cmd_i.step) begin
      unique case (cmd_i.phase)
        PH_GCD: begin
          priority if (!ra_q[0] && !rb_q[0]) begin
            ra_q <= ra_q >> 1;
            rb_q <= rb_q >> 1;
            k_q  <= k_q + KW'(1);
          end else if (!ra_q[0]) begin
            ra_q <= ra_q >> 1;
          end else if (!rb_q[0]) begin
            rb_q <= rb_q >> 1;
          end else if (ra_q >= rb_q) begin
            ra_q <= (ra_q - rb_q) >> 1;
          end else begin
            rb_q <= (rb_q - ra_q) >> 1;
          end
        end
        PH_DIVN, PH_DIVD: begin
          rr_q  <= div_ge ? div_sub[W-1:0] : div_sh[W-1:0];
          ra_q  <= {ra_q[W-2:0], div_ge};
          cnt_q <= cnt_q - CW'(1);
        end
        default: begin
          rr_q  <= rr_q + (rb_q[0] ? ra_q : '0);
          ra_q  <= ra_q << 1;
          rb_q  <= rb_q >> 1;
          cnt_q <= cnt_q - CW'(1);
        end
      endcase
    end
    if (cmd_i.commit) begin
      unique case (cmd_i.phase)
        PH_MUL0: rn_q <= rr_q;
        PH_MUL1: begin
          if (is_add) rn_q <= rn_q + rr_q;
          else rd_q <= rr_q;
        end
        PH_MUL2: rd_q <= rr_q;
        PH_GCD:  g_q  <= rb_q << k_q;
        PH_DIVN: qn_q <= ra_q;
        default: qd_q <= ra_q;
      endcase
    end
    if (cmd_i.out_load) begin
      oerr_q <= err_q;
      if (err_q) begin
        onum_q <= '0;
        oden_q <= '0;
      end else begin
        onum_q <= 32'(signed'(wn));
        oden_q <= (qn_q == '0) ? 31'd1 : 31'(qd_q);
      end
    end
  end

  assign result_num_o     = onum_q;
  assign result_den_o     = oden_q;
  assign zero_den_error_o = oerr_q;

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational reduce/negate/add/multiply/divide with GCD reduction.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+-------------------------------
// in      | input     | in_valid_i / in_stall_o| kind, first/second num/den
// out     | output    | out_valid_o/out_stall_i| result_num, result_den, error
//
// Per request: add forms three products, multiply/divide two (shift-add, one
// bit per cycle, plus a setup and a commit step per product), then a binary
// GCD and two restoring divides, each with its own setup and commit; capture,
// dispatch, prep and output steps come on top.
// Reduce and negate skip the multiplies. A zero denominator skips GCD/divide.
// Reset is asynchronous, active low; it clears only control state.
// One request in flight; in_stall_o is high while it is worked on. A result
// held by out_stall_i does not block the next request from being taken.
//
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rau_pkg::KIND_BITS-1:0] kind_i,
  input  logic signed [31:0]            first_num_i,
  input  logic signed [31:0]            first_den_i,
  input  logic signed [31:0]            second_num_i,
  input  logic signed [31:0]            second_den_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            result_num_o,
  output logic [30:0]                   result_den_o,
  output logic                          zero_den_error_o
);
  import rau_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and result register
  rau_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .kind_i           (kind_i),
    .first_num_i      (first_num_i),
    .first_den_i      (first_den_i),
    .second_num_i     (second_num_i),
    .second_den_i     (second_den_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .result_num_o     (result_num_o),
    .result_den_o     (result_den_o),
    .zero_den_error_o (zero_den_error_o)
  );

  // a taken request keeps the input side busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_den_error_o) |-> (result_num_o == '0 && result_den_o == '0))
    else $error("error result not zero");

  // zero numerator reads 0/1
  a_zero_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !zero_den_error_o && result_num_o == '0) |-> (result_den_o == 31'd1))
    else $error("zero numerator without unit denominator");

endmodule
